@@ src/ptts_pkg.sv @@
// Shared constants, codes and types for the periodic task tick scheduler.
`timescale 1ns / 1ps
package ptts_pkg;

	localparam int DATA_W        = 32;
	localparam int PRIO_W        = 8;
	localparam int KIND_W        = 2;
	localparam int TIDX_W        = 4;
	localparam int DEF_MAX_TASKS = 16;
	localparam int APB_ADDR_W    = 3;

	localparam logic [APB_ADDR_W-1:0] REG_TICK_RATE = '0;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED    = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_DUE      = 2'd2,
		KIND_IDLE     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_ADD_DIV,
		ST_TICK_RD,
		ST_TICK_WB,
		ST_SORT_RD_I,
		ST_SORT_LD_I,
		ST_SORT_RD_J,
		ST_SORT_CMP_J,
		ST_EMIT
	} state_t;

	// divider handshake towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ src/ptts_if.sv @@
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface ptts_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [ptts_pkg::DATA_W-1:0]  frequency;
	logic [ptts_pkg::PRIO_W-1:0]  priority_req;

	modport source (output valid, mode, frequency, priority_req, input ready);
	modport sink   (input valid, mode, frequency, priority_req, output ready);
endinterface

interface ptts_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ptts_pkg::KIND_W-1:0]  kind;
	logic [ptts_pkg::TIDX_W-1:0]  task_index;
	logic                         last;

	modport source (output valid, kind, task_index, last, input ready);
	modport sink   (input valid, kind, task_index, last, output ready);
endinterface

@@ src/periodic_task_tick_scheduler.sv @@
// Top level: periodic task table, tick sequencer and due-task ordering.
`timescale 1ns / 1ps
// Periodic task tick scheduler. Requests on req either add a task (mode 0) or
// report one elapsed tick (mode 1); results leave on rsp, one beat each,
// with last set on the final beat for a request. The block takes one request
// at a time and drops ready until its last result beat is loaded into the
// output register. An add scans the slots for a free one and then runs the
// bit-serial divider, which yields 32 quotient bits and then a done pulse.
// A tick walks every slot through the slot memory, which has one write and
// one registered read port, then orders the n due tasks by an exchange sort
// over the due list memory; any output stall holds the beats back. tick_rate
// is written over APB at byte address 0 and should only be changed while the
// block is idle; it affects later adds only. No clearing pass after reset:
// slot contents are only used once the slot has been filled by an add.
module periodic_task_tick_scheduler #(
	parameter int MAX_TASKS = ptts_pkg::DEF_MAX_TASKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ptts_req_if.sink                        req,
	ptts_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ptts_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ptts_pkg::DATA_W-1:0]     pwdata,
	output logic [ptts_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	localparam int W  = ptts_pkg::DATA_W;
	localparam int PW = ptts_pkg::PRIO_W;
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] N_SLOTS = CW'(MAX_TASKS);

	typedef struct packed {
		logic [W-1:0]  interval;
		logic [W-1:0]  countdown;
		logic [PW-1:0] prio;
	} slot_t;

	typedef struct packed {
		logic [IW-1:0] idx;
		logic [PW-1:0] prio;
	} due_t;

	// APB register
	logic [W-1:0] tick_rate_q;
	logic         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ptts_pkg::APB_ADDR_W-1] == ptts_pkg::REG_TICK_RATE[
		ptts_pkg::APB_ADDR_W-1]);
	assign prdata  = reg_sel ? tick_rate_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			tick_rate_q <= pwdata;
		end
	end

	// sequencer state
	ptts_pkg::state_t state_q, state_d;
	logic [MAX_TASKS-1:0] active_q;
	logic [CW-1:0] ptr_q, ptr_d;        // slot scan / inner sort pointer
	logic [CW-1:0] pos_q, pos_d;        // outer sort position
	logic [CW-1:0] n_q, n_d;            // due count
	logic [IW-1:0] cur_idx_q, cur_idx_d;
	logic [PW-1:0] cur_prio_q, cur_prio_d;
	logic [W-1:0]  freq_q;
	logic [PW-1:0] prio_q;
	ptts_pkg::kind_t res_kind_q, res_kind_d;
	logic [IW-1:0] res_idx_q, res_idx_d;
	logic          res_last_q, res_last_d;

	// output register
	logic                    out_valid_q;
	ptts_pkg::kind_t         out_kind_q;
	logic [ptts_pkg::TIDX_W-1:0] out_idx_q;
	logic                    out_last_q;
	logic                    out_free;
	logic                    out_load;

	// memories
	slot_t slot_mem [MAX_TASKS];
	slot_t slot_rd_q;
	logic [IW-1:0] slot_raddr;
	logic          slot_we;
	logic [IW-1:0] slot_waddr;
	slot_t         slot_wdata;

	due_t  due_mem [MAX_TASKS];
	due_t  due_rd_q;
	logic [IW-1:0] due_raddr;
	logic          due_we;
	logic [IW-1:0] due_waddr;
	due_t          due_wdata;

	// divider
	logic                div_start;
	ptts_pkg::div_stat_t div_stat;
	logic [W-1:0]        div_quo;
	logic [W-1:0]        interval;
	logic                accept;
	logic                set_active;
	logic [W-1:0]        cd_dec;

	ptts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tick_rate_q),
		.divisor  (freq_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign interval = (div_quo == '0) ? W'(1) : div_quo;
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cd_dec   = slot_rd_q.countdown - 1'b1;

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		pos_d      = pos_q;
		n_d        = n_q;
		cur_idx_d  = cur_idx_q;
		cur_prio_d = cur_prio_q;
		res_kind_d = res_kind_q;
		res_idx_d  = res_idx_q;
		res_last_d = res_last_q;
		req.ready  = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		set_active = 1'b0;
		slot_raddr = ptr_q[IW-1:0];
		slot_we    = 1'b0;
		slot_waddr = ptr_q[IW-1:0];
		slot_wdata = slot_rd_q;
		due_raddr  = ptr_q[IW-1:0];
		due_we     = 1'b0;
		due_waddr  = ptr_q[IW-1:0];
		due_wdata  = '{idx: cur_idx_q, prio: cur_prio_q};
		unique case (state_q)
			ptts_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				ptr_d     = '0;
				n_d       = '0;
				if (req.valid) begin
					if (req.mode) begin
						state_d = ptts_pkg::ST_TICK_RD;
					end else if (req.frequency == '0 || req.frequency > tick_rate_q) begin
						res_kind_d = ptts_pkg::KIND_REJECTED;
						res_idx_d  = '0;
						res_last_d = 1'b1;
						state_d    = ptts_pkg::ST_EMIT;
					end else begin
						state_d = ptts_pkg::ST_ADD_SCAN;
					end
				end
			end
			ptts_pkg::ST_ADD_SCAN: begin
				priority if (ptr_q == N_SLOTS) begin
					res_kind_d = ptts_pkg::KIND_REJECTED;
					res_idx_d  = '0;
					res_last_d = 1'b1;
					state_d    = ptts_pkg::ST_EMIT;
				end else if (!active_q[ptr_q[IW-1:0]]) begin
					div_start = 1'b1;
					state_d   = ptts_pkg::ST_ADD_DIV;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ptts_pkg::ST_ADD_DIV: begin
				if (div_stat.done) begin
					slot_we    = 1'b1;
					slot_wdata = '{interval: interval, countdown: interval, prio: prio_q};
					set_active = 1'b1;
					res_kind_d = ptts_pkg::KIND_ADDED;
					res_idx_d  = ptr_q[IW-1:0];
					res_last_d = 1'b1;
					state_d    = ptts_pkg::ST_EMIT;
				end
			end
			ptts_pkg::ST_TICK_RD: begin
				priority if (ptr_q == N_SLOTS) begin
					if (n_q == '0) begin
						res_kind_d = ptts_pkg::KIND_IDLE;
						res_idx_d  = '0;
						res_last_d = 1'b1;
						state_d    = ptts_pkg::ST_EMIT;
					end else begin
						pos_d   = '0;
						state_d = ptts_pkg::ST_SORT_RD_I;
					end
				end else if (active_q[ptr_q[IW-1:0]]) begin
					state_d = ptts_pkg::ST_TICK_WB;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ptts_pkg::ST_TICK_WB: begin
				// countdown hits zero: reload now, queue slot for ordering; else store it decremented
				slot_we = 1'b1;
				if (cd_dec == '0) begin
					slot_wdata.countdown = slot_rd_q.interval;
					due_we    = 1'b1;
					due_waddr = n_q[IW-1:0];
					due_wdata = '{idx: ptr_q[IW-1:0], prio: slot_rd_q.prio};
					n_d       = n_q + 1'b1;
				end else begin
					slot_wdata.countdown = cd_dec;
				end
				ptr_d   = ptr_q + 1'b1;
				state_d = ptts_pkg::ST_TICK_RD;
			end
			ptts_pkg::ST_SORT_RD_I: begin
				due_raddr = pos_q[IW-1:0];
				state_d   = ptts_pkg::ST_SORT_LD_I;
			end
			ptts_pkg::ST_SORT_LD_I: begin
				cur_idx_d  = due_rd_q.idx;
				cur_prio_d = due_rd_q.prio;
				ptr_d      = pos_q + 1'b1;
				state_d    = ptts_pkg::ST_SORT_RD_J;
			end
			ptts_pkg::ST_SORT_RD_J: begin
				if (ptr_q == n_q) begin
					res_kind_d = ptts_pkg::KIND_DUE;
					res_idx_d  = cur_idx_q;
					res_last_d = (pos_q + 1'b1 == n_q);
					state_d    = ptts_pkg::ST_EMIT;
				end else begin
					state_d = ptts_pkg::ST_SORT_CMP_J;
				end
			end
			ptts_pkg::ST_SORT_CMP_J: begin
				// strictly lower priority swaps into the current position
				if (due_rd_q.prio < cur_prio_q) begin
					due_we     = 1'b1;
					cur_idx_d  = due_rd_q.idx;
					cur_prio_d = due_rd_q.prio;
				end
				ptr_d   = ptr_q + 1'b1;
				state_d = ptts_pkg::ST_SORT_RD_J;
			end
			ptts_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (res_last_q) begin
						state_d = ptts_pkg::ST_IDLE;
					end else begin
						pos_d   = pos_q + 1'b1;
						state_d = ptts_pkg::ST_SORT_RD_I;
					end
				end
			end
			default: state_d = ptts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptts_pkg::ST_IDLE;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			pos_q       <= '0;
			n_q         <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			pos_q   <= pos_d;
			n_q     <= n_d;
			if (set_active) begin
				active_q[ptr_q[IW-1:0]] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_idx_q  <= cur_idx_d;
		cur_prio_q <= cur_prio_d;
		res_kind_q <= res_kind_d;
		res_idx_q  <= res_idx_d;
		res_last_q <= res_last_d;
		if (accept) begin
			freq_q <= req.frequency;
			prio_q <= req.priority_req;
		end
		if (out_load) begin
			out_kind_q <= res_kind_q;
			out_idx_q  <= ptts_pkg::TIDX_W'(res_idx_q);
			out_last_q <= res_last_q;
		end
	end

	// slot table: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// due list
	always_ff @(posedge clk) begin
		if (due_we) begin
			due_mem[due_waddr] <= due_wdata;
		end
		due_rd_q <= due_mem[due_raddr];
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.task_index = out_idx_q;
	assign rsp.last       = out_last_q;
endmodule

@@ src/ptts_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ptts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ptts_pkg::DATA_W-1:0] dividend,
	input  logic [ptts_pkg::DATA_W-1:0] divisor,
	output ptts_pkg::div_stat_t         stat,
	output logic [ptts_pkg::DATA_W-1:0] quotient
);
	localparam int W  = ptts_pkg::DATA_W;
	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_sh;
	logic [W:0]    diff;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the periodic task tick scheduler.
`timescale 1ns / 1ps
module tb;

	localparam int SLOTS      = ptts_pkg::DEF_MAX_TASKS;
	localparam int SETTLE     = 400;   // cycles after the last result before a rate change
	localparam int STALL_LIM  = 6000;  // cycles with no beat before giving up
	localparam int RAND_ITEMS = 250;

	typedef struct packed {
		ptts_pkg::kind_t kind;
		logic [3:0]      slot;
		logic            last;
	} sched_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ptts_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ptts_pkg::DATA_W-1:0] pwdata = '0;
	logic [ptts_pkg::DATA_W-1:0] prdata;
	logic pready;

	ptts_req_if req ();
	ptts_rsp_if rsp ();

	periodic_task_tick_scheduler dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// shadow of the task table
	logic [ptts_pkg::DATA_W-1:0] rate_shadow;
	logic                        act_sh  [SLOTS];
	logic [ptts_pkg::DATA_W-1:0] ivl_sh  [SLOTS];
	logic [ptts_pkg::DATA_W-1:0] cnt_sh  [SLOTS];
	logic [ptts_pkg::PRIO_W-1:0] prio_sh [SLOTS];

	sched_beat_t due_q[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;   // no idling on either side while set

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	// Work out what one accepted request must produce.
	task automatic predict_beats(input logic mode, input logic [ptts_pkg::DATA_W-1:0] freq,
			input logic [ptts_pkg::PRIO_W-1:0] prio);
		int due[$];
		int t, s;
		logic [ptts_pkg::DATA_W-1:0] ivl;
		sched_beat_t b;
		if (mode == 1'b0) begin
			b = '{ptts_pkg::KIND_REJECTED, 4'd0, 1'b1};
			if (freq != 0 && freq <= rate_shadow) begin
				ivl = rate_shadow / freq;
				if (ivl == 0) ivl = 1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!act_sh[i]) begin
						act_sh[i] = 1'b1;
						ivl_sh[i] = ivl;
						cnt_sh[i] = ivl;
						prio_sh[i] = prio;
						b = '{ptts_pkg::KIND_ADDED, 4'(i), 1'b1};
						break;
					end
				end
			end
			due_q.push_back(b);
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (act_sh[i]) begin
					cnt_sh[i] = cnt_sh[i] - 1;
					if (cnt_sh[i] == 0) due.push_back(i);
				end
			end
			if (due.size() == 0) begin
				due_q.push_back('{ptts_pkg::KIND_IDLE, 4'd0, 1'b1});
			end else begin
				// exchange sort, same tie behaviour as the block
				for (int i = 0; i < due.size() - 1; i++)
					for (int j = i + 1; j < due.size(); j++)
						if (prio_sh[due[j]] < prio_sh[due[i]]) begin
							t = due[i];
							due[i] = due[j];
							due[j] = t;
						end
				for (int i = 0; i < due.size(); i++) begin
					s = due[i];
					cnt_sh[s] = ivl_sh[s];
					due_q.push_back('{ptts_pkg::KIND_DUE, 4'(s), i == due.size() - 1});
				end
			end
		end
	endtask

	// Send one request beat; valid is left high so back-to-back beats stay gapless.
	task automatic send_req(input logic mode, input logic [ptts_pkg::DATA_W-1:0] freq,
			input logic [ptts_pkg::PRIO_W-1:0] prio);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid = 1'b1;
		req.mode = mode;
		req.frequency = freq;
		req.priority_req = prio;
		do @(posedge clk); while (!req.ready);
		predict_beats(mode, freq, prio);
	endtask

	task automatic send_tick();
		send_req(1'b1, $urandom, ptts_pkg::PRIO_W'($urandom));
	endtask

	// Hold off until every expected beat has arrived, then let the block settle.
	task automatic drain_all();
		@(negedge clk);
		req.valid = 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_rate(input logic [ptts_pkg::DATA_W-1:0] value);
		drain_all();
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = ptts_pkg::REG_TICK_RATE; pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rate_shadow = value;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// Zero tick rate: every add is refused, a tick on an empty table is idle.
	task automatic test_zero_rate();
		write_rate('0);
		send_req(1'b0, 32'd1, 8'd0);
		send_req(1'b0, 32'd0, 8'hFF);
		send_tick();
	endtask

	// Full-scale rate: interval of one, huge interval, first due ordering.
	task automatic test_extreme_rate();
		write_rate(32'hFFFF_FFFF);
		send_req(1'b0, 32'hFFFF_FFFF, 8'hFF);
		send_req(1'b0, 32'd1, 8'd0);
		send_req(1'b0, 32'h8000_0000, 8'd7);
		send_req(1'b0, 32'd0, 8'd9);
		send_tick();
		send_tick();
	endtask

	// Small rate, several tasks sharing a priority so ties get sorted.
	task automatic test_small_rate_ties();
		write_rate(32'd6);
		send_req(1'b0, 32'd7, 8'd3);
		send_req(1'b0, 32'd6, 8'd3);
		send_req(1'b0, 32'd3, 8'd3);
		send_req(1'b0, 32'd2, 8'd3);
		send_req(1'b0, 32'd1, 8'd1);
		repeat (6) send_tick();
	endtask

	// Random phases at several rates; the last one at full scale with wide frequencies.
	task automatic test_random();
		logic [ptts_pkg::DATA_W-1:0] f;
		logic [ptts_pkg::PRIO_W-1:0] p;
		int r;
		for (int ph = 0; ph < 5; ph++) begin
			write_rate(ph == 4 ? 32'hFFFF_FFFF
				: ptts_pkg::DATA_W'($urandom_range(1, 12)));
			calm = (ph == 2);
			for (int n = 0; n < RAND_ITEMS / 5; n++) begin
				if (n == 25) drain_all();   // sender waits for all results once per phase
				r = $urandom_range(0, 99);
				if (r < 72) begin
					send_tick();
				end else begin
					r = $urandom_range(0, 9);
					if (r == 0) f = '0;
					else if (r < 3 || ph == 4) f = $urandom;
					else f = ptts_pkg::DATA_W'($urandom_range(1, rate_shadow + 1));
					p = ($urandom_range(0, 1) != 0) ? ptts_pkg::PRIO_W'($urandom_range(0, 3))
						: ptts_pkg::PRIO_W'($urandom);
					send_req(1'b0, f, p);
				end
			end
		end
		calm = 1'b0;
	endtask

	// Result side: random back-pressure.
	int rdy_hold = 0;
	always @(negedge clk) begin
		if (rdy_hold > 0) begin
			rsp.ready <= 1'b0;
			rdy_hold <= rdy_hold - 1;
		end else begin
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 4) == 0) rdy_hold <= pick_gap();
		end
	end

	// Compare every result beat against the oldest expectation.
	always @(posedge clk) begin
		sched_beat_t exp_b;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat kind=%0d slot=%0d last=%0d",
						rsp.kind, rsp.task_index, rsp.last);
			end else begin
				exp_b = due_q.pop_front();
				if (rsp.kind !== exp_b.kind || rsp.task_index !== exp_b.slot
						|| rsp.last !== exp_b.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind=%0d slot=%0d last=%0d, got %0d %0d %0d",
							exp_b.kind, exp_b.slot, exp_b.last,
							rsp.kind, rsp.task_index, rsp.last);
				end
			end
		end
	end

	// Watchdog on beats moving on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIM) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.mode = 1'b0;
		req.frequency = '0;
		req.priority_req = '0;
		rsp.ready = 1'b0;
		rate_shadow = '0;
		for (int i = 0; i < SLOTS; i++) begin
			act_sh[i] = 1'b0;
			ivl_sh[i] = '0;
			cnt_sh[i] = '0;
			prio_sh[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_zero_rate();
		test_extreme_rate();
		test_small_rate_ties();
		test_random();
		drain_all();
		if (mismatches == 0 && due_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/ptts_pkg.sv
src/ptts_if.sv
src/ptts_div.sv
src/periodic_task_tick_scheduler.sv
sim/tb.sv
